### rtl/dhms_pkg.sv
// dhms_pkg: shared types and constants for the days/hours/minutes/seconds timer
// holds item structs, the split count type, command and register codes
// no dependencies
`default_nettype none

package dhms_pkg;

  // field widths of the split count
  localparam int unsigned DAY_W = 8;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned MS_W = 6;

  // preset limits and tick period
  localparam logic [DAY_W-1:0] MAX_DAYS = 8'd99;
  localparam logic [HOUR_W-1:0] MAX_HOURS = 5'd23;
  localparam logic [MS_W-1:0] MAX_MIN_SEC = 6'd59;
  localparam logic [31:0] ONE_SECOND_MS = 32'd1000;

  // fixed clock radix of the split count
  localparam logic [HOUR_W-1:0] LAST_HOUR = 5'd23;
  localparam logic [MS_W-1:0] LAST_MIN_SEC = 6'd59;

  // commands
  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_PAUSE = 3'd2;
  localparam logic [2:0] CMD_STOP = 3'd3;
  localparam logic [2:0] CMD_RESTART = 3'd4;
  localparam logic [2:0] CMD_LOAD = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_COUNT_MODE = 3'd0;
  localparam logic [2:0] REG_TICK_SOURCE = 3'd1;
  localparam logic [2:0] REG_PRESET_DAYS = 3'd2;
  localparam logic [2:0] REG_PRESET_HOURS = 3'd3;
  localparam logic [2:0] REG_PRESET_MINUTES = 3'd4;
  localparam logic [2:0] REG_PRESET_SECONDS = 3'd5;

  // count held as normalized days/hours/minutes/seconds; ordering of the
  // packed vector matches ordering of the seconds total
  typedef struct packed {
    logic [DAY_W-1:0]  days;
    logic [HOUR_W-1:0] hours;
    logic [MS_W-1:0]   minutes;
    logic [MS_W-1:0]   seconds;
  } dhms_t;

  // 16777215 seconds, the largest 24-bit count
  localparam dhms_t COUNT_SAT = '{days: 8'd194, hours: 5'd4, minutes: 6'd20, seconds: 6'd15};

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] now_ms;
    logic [7:0]  rtc_second;
  } timer_in_t;

  typedef struct packed {
    logic [6:0] days;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       running;
    logic       completed;
    logic       tick_pulse;
    logic       complete_pulse;
    logic       heartbeat;
  } timer_out_t;

endpackage

`default_nettype wire

### rtl/dhms_countdown_countup_timer.sv
// dhms_countdown_countup_timer: seconds timer counting down from, or up to, a preset
// holds command decode, split-count counter, output register and skid stage
// depends on dhms_pkg
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  in       | in_valid_i / in_ready_o | in_data_i  (timer_in_t)
//  out      | out_valid_o/out_ready_i | out_data_o (timer_out_t)
//  cfg      | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// one item per cycle while in_ready_o is high; each result is registered
// the whole command is applied in the accept cycle against the state registers
// the output register is backed by a one-entry skid stage, so input stalls only
// once both hold a waiting result
// reset: timer stopped, counts zero, no result pending
`default_nettype none

module dhms_countdown_countup_timer (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire dhms_pkg::timer_in_t   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output dhms_pkg::timer_out_t       out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [2:0]            cfg_idx_i,
  input  wire logic [7:0]            cfg_wdata_i
);
  import dhms_pkg::*;

  // configuration registers
  logic       mode_q;
  logic       src_q;
  logic [7:0] pre_days_q, pre_hours_q, pre_min_q, pre_sec_q;

  // timer state
  dhms_t       cur_q, cur_d;
  dhms_t       full_q, full_d;
  dhms_t       start_q, start_d;
  logic        stopped_q, stopped_d;
  logic        completed_q, completed_d;
  logic [31:0] last_ms_q, last_ms_d;
  logic [7:0]  last_rtc_q, last_rtc_d;
  logic        hb_q, hb_d;

  // output register and skid stage
  logic       out_vld_q, skid_vld_q;
  timer_out_t out_q, skid_q;

  logic       accept;
  logic       tick;
  logic       done;
  logic [31:0] ms_delta;
  dhms_t      preset;
  dhms_t      cur_dec, cur_inc;
  timer_out_t res;

  assign in_ready_o = !skid_vld_q;
  assign accept     = in_valid_i && in_ready_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      src_q       <= 1'b0;
      pre_days_q  <= '0;
      pre_hours_q <= '0;
      pre_min_q   <= '0;
      pre_sec_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COUNT_MODE:     mode_q      <= cfg_wdata_i[0];
        REG_TICK_SOURCE:    src_q       <= cfg_wdata_i[0];
        REG_PRESET_DAYS:    pre_days_q  <= cfg_wdata_i;
        REG_PRESET_HOURS:   pre_hours_q <= cfg_wdata_i;
        REG_PRESET_MINUTES: pre_min_q   <= cfg_wdata_i;
        REG_PRESET_SECONDS: pre_sec_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamped preset, saturated at the 24-bit limit
  always_comb begin
    dhms_t clamped;
    clamped.days    = (pre_days_q > MAX_DAYS) ? MAX_DAYS : pre_days_q;
    clamped.hours   = (pre_hours_q > 8'(MAX_HOURS)) ? MAX_HOURS : pre_hours_q[HOUR_W-1:0];
    clamped.minutes = (pre_min_q > 8'(MAX_MIN_SEC)) ? MAX_MIN_SEC : pre_min_q[MS_W-1:0];
    clamped.seconds = (pre_sec_q > 8'(MAX_MIN_SEC)) ? MAX_MIN_SEC : pre_sec_q[MS_W-1:0];
    preset = (clamped > COUNT_SAT) ? COUNT_SAT : clamped;
  end

  // mixed-radix decrement with borrow
  always_comb begin
    cur_dec = cur_q;
    if (cur_q.seconds != '0) begin
      cur_dec.seconds = cur_q.seconds - 1'b1;
    end else begin
      cur_dec.seconds = LAST_MIN_SEC;
      if (cur_q.minutes != '0) begin
        cur_dec.minutes = cur_q.minutes - 1'b1;
      end else begin
        cur_dec.minutes = LAST_MIN_SEC;
        if (cur_q.hours != '0) begin
          cur_dec.hours = cur_q.hours - 1'b1;
        end else begin
          cur_dec.hours = LAST_HOUR;
          cur_dec.days  = cur_q.days - 1'b1;
        end
      end
    end
  end

  // mixed-radix increment with carry
  always_comb begin
    cur_inc = cur_q;
    if (cur_q.seconds != LAST_MIN_SEC) begin
      cur_inc.seconds = cur_q.seconds + 1'b1;
    end else begin
      cur_inc.seconds = '0;
      if (cur_q.minutes != LAST_MIN_SEC) begin
        cur_inc.minutes = cur_q.minutes + 1'b1;
      end else begin
        cur_inc.minutes = '0;
        if (cur_q.hours != LAST_HOUR) begin
          cur_inc.hours = cur_q.hours + 1'b1;
        end else begin
          cur_inc.hours = '0;
          cur_inc.days  = cur_q.days + 1'b1;
        end
      end
    end
  end

  assign ms_delta = in_data_i.now_ms - last_ms_q;

  // command decode and next state
  always_comb begin
    cur_d       = cur_q;
    full_d      = full_q;
    start_d     = start_q;
    stopped_d   = stopped_q;
    completed_d = completed_q;
    last_ms_d   = last_ms_q;
    last_rtc_d  = last_rtc_q;
    hb_d        = hb_q;
    tick        = 1'b0;
    done        = 1'b0;
    case (in_data_i.command)
      CMD_TICK: begin
        if (!completed_q && !stopped_q) begin
          if (src_q) begin
            if (ms_delta >= ONE_SECOND_MS) begin
              last_ms_d = in_data_i.now_ms;
              tick      = 1'b1;
            end
          end else if (in_data_i.rtc_second != last_rtc_q) begin
            last_rtc_d = in_data_i.rtc_second;
            tick       = 1'b1;
          end
          if (tick) begin
            hb_d = !hb_q;
            if (!mode_q && (cur_q != '0)) begin
              cur_d = cur_dec;
            end else if (mode_q && (cur_q < full_q)) begin
              cur_d = cur_inc;
            end else begin
              done        = 1'b1;
              stopped_d   = 1'b1;
              completed_d = 1'b1;
              cur_d       = mode_q ? '0 : full_q;
            end
          end
        end
      end
      CMD_START: begin
        stopped_d   = 1'b0;
        completed_d = 1'b0;
      end
      CMD_PAUSE: begin
        stopped_d = 1'b1;
      end
      CMD_STOP: begin
        stopped_d   = 1'b1;
        completed_d = 1'b1;
        cur_d       = mode_q ? '0 : full_q;
      end
      CMD_RESTART: begin
        cur_d       = start_q;
        stopped_d   = 1'b0;
        completed_d = 1'b0;
      end
      CMD_LOAD: begin
        full_d  = preset;
        cur_d   = mode_q ? '0 : preset;
        start_d = mode_q ? '0 : preset;
      end
      default: ;
    endcase
  end

  // result from the state after the command
  always_comb begin
    res.days           = cur_d.days[6:0];
    res.hours          = cur_d.hours;
    res.minutes        = cur_d.minutes;
    res.seconds        = cur_d.seconds;
    res.running        = !stopped_d;
    res.completed      = completed_d;
    res.tick_pulse     = tick;
    res.complete_pulse = done;
    res.heartbeat      = hb_d;
  end

  // state update on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      full_q      <= '0;
      start_q     <= '0;
      stopped_q   <= 1'b1;
      completed_q <= 1'b0;
      last_ms_q   <= '0;
      last_rtc_q  <= '0;
      hb_q        <= 1'b0;
    end else if (accept) begin
      cur_q       <= cur_d;
      full_q      <= full_d;
      start_q     <= start_d;
      stopped_q   <= stopped_d;
      completed_q <= completed_d;
      last_ms_q   <= last_ms_d;
      last_rtc_q  <= last_rtc_d;
      hb_q        <= hb_d;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= accept;
      end
    end else if (accept) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_ready_i) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // skid stage only fills behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid stage holds an item without a pending output");

  // stored count stays in clock radix
  a_count_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q.hours <= LAST_HOUR) && (cur_q.minutes <= LAST_MIN_SEC) &&
    (cur_q.seconds <= LAST_MIN_SEC))
    else $error("current count left clock radix");

  // a finishing item is a tick and leaves the timer stopped and completed
  a_complete_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.complete_pulse) |->
      (out_q.tick_pulse && out_q.completed && !out_q.running))
    else $error("complete pulse without stop and tick");

  // heartbeat toggles on every accepted advance
  a_heartbeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && tick) |=> (hb_q != $past(hb_q)))
    else $error("heartbeat did not toggle on advance");
`endif

endmodule

`default_nettype wire

### dv/tb_dhms_countdown_countup_timer.sv
// tb_dhms_countdown_countup_timer: self-checking bench for the d/h/m/s timer
// drives command items, predicts every readout and compares it field by field
// depends on dhms_pkg and dhms_countdown_countup_timer
`default_nettype none

module tb_dhms_countdown_countup_timer;
  timeunit 1ns;
  timeprecision 1ps;

  import dhms_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SECS_DAY = 86400;
  localparam int unsigned SECS_HOUR = 3600;
  localparam int unsigned SECS_MIN = 60;
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // dut ports
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  timer_in_t  in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  timer_out_t out_data_o;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [7:0] cfg_wdata_i = '0;

  dhms_countdown_countup_timer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // register mirror
  logic       mode_up = 1'b0;
  logic       src_ms = 1'b0;
  logic [7:0] preset_d = '0;
  logic [7:0] preset_h = '0;
  logic [7:0] preset_m = '0;
  logic [7:0] preset_s = '0;

  // timer state mirror
  logic [23:0] count_now = '0;
  logic [23:0] count_full = '0;
  logic [23:0] count_start = '0;
  logic        is_stopped = 1'b1;
  logic        is_done = 1'b0;
  logic [31:0] prev_ms = '0;
  logic [7:0]  prev_rtc = '0;
  logic        beat = 1'b0;

  // readouts still owed by the dut, oldest first
  timer_out_t pending_readouts[$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned readouts_seen = 0;
  logic        no_idle = 1'b0;
  logic [31:0] sim_now = '0;
  logic [7:0]  sim_rtc = '0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // stop or finish: reload the count for the current direction
  function automatic void halt_count();
    is_stopped = 1'b1;
    is_done = 1'b1;
    count_now = mode_up ? 24'd0 : count_full;
  endfunction

  // apply one command to the mirrored state and return the readout it causes
  function automatic timer_out_t apply_command(timer_in_t it);
    timer_out_t  res;
    logic        ticked;
    logic        finished;
    logic [31:0] delta;
    int unsigned d, h, m, s, total;
    ticked = 1'b0;
    finished = 1'b0;
    case (it.command)
      CMD_TICK: begin
        if (!is_done && !is_stopped) begin
          if (src_ms) begin
            delta = it.now_ms - prev_ms;
            if (delta >= ONE_SECOND_MS) begin
              prev_ms = it.now_ms;
              ticked = 1'b1;
            end
          end else if (it.rtc_second != prev_rtc) begin
            prev_rtc = it.rtc_second;
            ticked = 1'b1;
          end
          if (ticked) begin
            beat = ~beat;
            if (!mode_up && count_now > 0) count_now = count_now - 24'd1;
            else if (mode_up && count_now < count_full) count_now = count_now + 24'd1;
            else begin
              halt_count();
              finished = 1'b1;
            end
          end
        end
      end
      CMD_START: begin
        is_stopped = 1'b0;
        is_done = 1'b0;
      end
      CMD_PAUSE: is_stopped = 1'b1;
      CMD_STOP: halt_count();
      CMD_RESTART: begin
        count_now = count_start;
        is_done = 1'b0;
        is_stopped = 1'b0;
      end
      CMD_LOAD: begin
        d = (preset_d > MAX_DAYS) ? MAX_DAYS : preset_d;
        h = (preset_h > MAX_HOURS) ? MAX_HOURS : preset_h;
        m = (preset_m > MAX_MIN_SEC) ? MAX_MIN_SEC : preset_m;
        s = (preset_s > MAX_MIN_SEC) ? MAX_MIN_SEC : preset_s;
        total = d * SECS_DAY + h * SECS_HOUR + m * SECS_MIN + s;
        if (total > 32'hFF_FFFF) total = 32'hFF_FFFF;
        count_full = 24'(total);
        count_now = mode_up ? 24'd0 : count_full;
        count_start = count_now;
      end
      default: ;
    endcase
    res.days = 7'(count_now / SECS_DAY);
    res.hours = 5'((count_now % SECS_DAY) / SECS_HOUR);
    res.minutes = 6'((count_now % SECS_HOUR) / SECS_MIN);
    res.seconds = 6'(count_now % SECS_MIN);
    res.running = ~is_stopped;
    res.completed = is_done;
    res.tick_pulse = ticked;
    res.complete_pulse = finished;
    res.heartbeat = beat;
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at readout %0d: %s", readouts_seen, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // send one item, predict its readout once accepted
  task automatic send_command(input logic [2:0] cmd, input logic [31:0] now,
                              input logic [7:0] rtc);
    timer_in_t   it;
    int unsigned gap;
    it.command = cmd;
    it.now_ms = now;
    it.rtc_second = rtc;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    pending_readouts.push_back(apply_command(it));
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drop valid and let every owed readout arrive, then idle with the input held low
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write all six registers while the timer is quiet
  task automatic write_settings(input logic mode, input logic src, input logic [7:0] d,
                                input logic [7:0] h, input logic [7:0] m,
                                input logic [7:0] s);
    logic [2:0] regs[6];
    logic [7:0] vals[6];
    regs = '{REG_COUNT_MODE, REG_TICK_SOURCE, REG_PRESET_DAYS, REG_PRESET_HOURS,
             REG_PRESET_MINUTES, REG_PRESET_SECONDS};
    vals = '{{7'd0, mode}, {7'd0, src}, d, h, m, s};
    wait_quiet();
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= regs[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    mode_up = mode;
    src_ms = src;
    preset_d = d;
    preset_h = h;
    preset_m = m;
    preset_s = s;
  endtask

  // a tick and both spare codes while stopped after reset
  task automatic test_idle_commands();
    send_command(CMD_TICK, 32'd5000, 8'd1);
    send_command(CMD_SPARE_LO, 32'hFFFF_FFFF, 8'hFF);
    send_command(CMD_SPARE_HI, 32'd0, 8'd0);
  endtask

  // count down on rtc changes through completion, then restart, pause, stop
  task automatic test_countdown_rtc();
    write_settings(1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd2);
    send_command(CMD_LOAD, 32'd0, 8'd0);
    send_command(CMD_START, 32'd0, 8'd0);
    send_command(CMD_TICK, 32'd0, 8'd5);
    send_command(CMD_TICK, 32'd0, 8'd5);
    send_command(CMD_TICK, 32'd0, 8'd6);
    send_command(CMD_TICK, 32'd0, 8'd7);
    send_command(CMD_TICK, 32'd0, 8'd8);
    send_command(CMD_RESTART, 32'd0, 8'd8);
    send_command(CMD_PAUSE, 32'd0, 8'd9);
    send_command(CMD_STOP, 32'd0, 8'd9);
  endtask

  // count up on millisecond deltas, across the timestamp wrap
  task automatic test_countup_ms_wrap();
    write_settings(1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 8'd1);
    send_command(CMD_LOAD, 32'd0, 8'd0);
    send_command(CMD_START, 32'd0, 8'd0);
    send_command(CMD_TICK, 32'd999, 8'd3);
    send_command(CMD_TICK, 32'hFFFF_FF00, 8'd3);
    send_command(CMD_TICK, 32'h0000_02E7, 8'd4);
    send_command(CMD_TICK, 32'h0000_02E8, 8'd4);
  endtask

  // presets above their limits clamp; switching to count-up after load
  task automatic test_clamp_and_mode_switch();
    write_settings(1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_command(CMD_LOAD, 32'd0, 8'd0);
    write_settings(1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_command(CMD_START, 32'd0, 8'd0);
    send_command(CMD_TICK, 32'd0, prev_rtc + 8'd1);
  endtask

  // zero preset finishes on the first tick
  task automatic test_zero_preset();
    write_settings(1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
    send_command(CMD_LOAD, 32'd0, 8'd0);
    send_command(CMD_START, 32'd0, 8'd0);
    send_command(CMD_TICK, prev_ms + ONE_SECOND_MS, 8'd0);
  endtask

  function automatic logic [7:0] pick_preset(input int unsigned lim);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'hFF;
    if (r < 20) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, lim));
  endfunction

  // random phases: load, start, then mostly ticks with a mix of other commands
  task automatic test_random_runs();
    int unsigned r;
    int unsigned len;
    logic [2:0]  cmd;
    for (int phase = 0; phase < 10; phase++) begin
      write_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_preset(0),
                     pick_preset(0), pick_preset(1), pick_preset(8));
      no_idle = ($urandom_range(0, 3) == 0);
      send_command(CMD_LOAD, $urandom, 8'($urandom));
      send_command(CMD_START, $urandom, 8'($urandom));
      len = $urandom_range(40, 56);
      for (int n = 0; n < len; n++) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          if ((is_stopped || is_done) && $urandom_range(0, 2) == 0) begin
            cmd = $urandom_range(0, 1) ? CMD_START : CMD_RESTART;
            send_command(cmd, $urandom, 8'($urandom));
          end else begin
            r = $urandom_range(0, 99);
            if (r < 80) sim_rtc = sim_rtc + 8'd1;
            else if (r >= 90) sim_rtc = 8'($urandom);
            r = $urandom_range(0, 99);
            if (r < 70) sim_now = sim_now + $urandom_range(1000, 1500);
            else if (r < 85) sim_now = sim_now + $urandom_range(0, 999);
            else sim_now = $urandom;
            send_command(CMD_TICK, sim_now, sim_rtc);
          end
        end else begin
          if (r < 79) cmd = CMD_START;
          else if (r < 82) cmd = CMD_PAUSE;
          else if (r < 85) cmd = CMD_STOP;
          else if (r < 90) cmd = CMD_RESTART;
          else if (r < 94) cmd = CMD_LOAD;
          else cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
          send_command(cmd, $urandom, 8'($urandom));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // receiver stalls: runs of ready with short or long gaps
  initial begin
    int unsigned hold;
    int unsigned r;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          out_ready_i <= 1'b1;
          hold = $urandom_range(30, 80);
        end else if (r < 65) begin
          out_ready_i <= 1'b1;
          hold = $urandom_range(0, 6);
        end else if (r < 93) begin
          out_ready_i <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          out_ready_i <= 1'b0;
          hold = $urandom_range(10, 25);
        end
      end
    end
  end

  // compare each accepted readout with the oldest prediction
  always @(posedge clk_i) begin : check_readouts
    timer_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_readouts.size() == 0) begin
        report_mismatch("readout with no item outstanding");
      end else begin
        want = pending_readouts.pop_front();
        check_field("days", out_data_o.days, want.days);
        check_field("hours", out_data_o.hours, want.hours);
        check_field("minutes", out_data_o.minutes, want.minutes);
        check_field("seconds", out_data_o.seconds, want.seconds);
        check_field("running", out_data_o.running, want.running);
        check_field("completed", out_data_o.completed, want.completed);
        check_field("tick_pulse", out_data_o.tick_pulse, want.tick_pulse);
        check_field("complete_pulse", out_data_o.complete_pulse, want.complete_pulse);
        check_field("heartbeat", out_data_o.heartbeat, want.heartbeat);
      end
      readouts_seen++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // test sequence
  initial begin
    sim_now = $urandom;
    sim_rtc = 8'($urandom);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_commands();
    test_countdown_rtc();
    test_countup_ms_wrap();
    test_clamp_and_mode_switch();
    test_zero_preset();
    test_random_runs();
    wait_quiet();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
